// ----- hdl/cts_pkg.sv -----
// Shared constants and the CORDIC angle table function for the spherical converter.
package cts_pkg;

  // Datapath width of the CORDIC vectors and of the angle accumulator
  localparam int unsigned CORDIC_W = 64;

  // floor(2^64 * 2/pi), maps Q0.64 radians to a full-turn binary angle
  localparam logic [CORDIC_W-1:0] ATAN_SCALE = 64'hA2F9836E4E441529;

  // Elaboration-time long division of a 64-bit value by a small odd number
  function automatic logic [CORDIC_W-1:0] cts_div(input logic [CORDIC_W-1:0] num,
                                                  input logic [CORDIC_W-1:0] den);
    logic [CORDIC_W:0]   rem_v;
    logic [CORDIC_W-1:0] quo;
    rem_v = '0;
    quo   = '0;
    for (int b = CORDIC_W - 1; b >= 0; b--) begin
      rem_v = {rem_v[CORDIC_W-1:0], num[b]};
      if (rem_v >= {1'b0, den}) begin
        rem_v  = rem_v - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Angle of one CORDIC step, 2^64 = 2*pi, from the truncated arctan series
  function automatic logic [CORDIC_W-1:0] cts_atan(input int unsigned idx);
    logic [CORDIC_W-1:0]   sum;
    logic [CORDIC_W-1:0]   term;
    logic [2*CORDIC_W-1:0] prod;
    logic                  add;
    sum  = '0;
    add  = 1'b1;
    prod = '0;
    if (idx == 0) begin
      return 64'h2000000000000000;
    end
    for (int unsigned k = 1; idx * k < CORDIC_W; k += 2) begin
      term = cts_div(64'd1 << (CORDIC_W - idx * k), 64'(k));
      sum  = add ? sum + term : sum - term;
      add  = !add;
    end
    prod = {64'd0, sum} * {64'd0, ATAN_SCALE};
    return CORDIC_W'(prod[2*CORDIC_W-1:CORDIC_W+2]);
  endfunction

endpackage

// ----- hdl/cts_delay.sv -----
// Enabled shift line that keeps side data aligned with the long pipeline paths.
module cts_delay
  import cts_pkg::*;
#(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  // Advance the whole line on enable, hold otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

// ----- hdl/cts_sqrt.sv -----
// Pipelined restoring square root, one root bit per stage, rounded to nearest.
module cts_sqrt
  import cts_pkg::*;
#(
  parameter int unsigned RW = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] sq,
  output logic [RW-1:0]   root
);

  localparam int unsigned MW = RW + 2;

  logic [2*RW-1:0] sv   [RW+1];
  logic [MW-1:0]   rem  [RW+1];
  logic [RW-1:0]   part [RW+1];
  logic [RW-1:0]   root_r;

  assign sv[0]   = sq;
  assign rem[0]  = '0;
  assign part[0] = '0;

  for (genvar k = 0; k < RW; k++) begin : g_bit
    logic [MW-1:0] rem_sh;
    logic [MW-1:0] trial;
    logic          fits;

    // Bring down the next pair of radicand bits and try a one
    always_comb begin
      rem_sh = {rem[k][MW-3:0], sv[k][2*RW-1:2*RW-2]};
      trial  = {part[k], 2'b01};
      fits   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sv[k+1]   <= sv[k] << 2;
        rem[k+1]  <= fits ? rem_sh - trial : rem_sh;
        part[k+1] <= {part[k][RW-2:0], fits};
      end
    end
  end

  // Round up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= part[RW] + RW'(rem[RW] > {2'b00, part[RW]});
    end
  end

  assign root = root_r;

endmodule

// ----- hdl/cts_cordic.sv -----
// Pipelined vectoring CORDIC, one rotation per stage, angle rounded at the end.
module cts_cordic
  import cts_pkg::*;
#(
  parameter int unsigned STAGES = 32,
  parameter int unsigned AW     = 32
) (
  input  logic                clk,
  input  logic                en,
  input  logic [CORDIC_W-1:0] vec_x,
  input  logic [CORDIC_W-1:0] vec_y,
  input  logic [CORDIC_W-1:0] base,
  input  logic                zero,
  output logic [AW-1:0]       angle
);

  logic [CORDIC_W-1:0] xs  [STAGES+1];
  logic [CORDIC_W-1:0] ys  [STAGES+1];
  logic [CORDIC_W-1:0] acc [STAGES+1];
  logic                zf  [STAGES+1];
  logic [AW-1:0]       angle_r;
  logic [CORDIC_W-1:0] acc_rnd;

  assign xs[0]  = vec_x;
  assign ys[0]  = vec_y;
  assign acc[0] = base;
  assign zf[0]  = zero;

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic [CORDIC_W-1:0] ATAN_I = cts_atan(i);
    logic [CORDIC_W-1:0] xsh;
    logic [CORDIC_W-1:0] ysh;

    assign xsh = CORDIC_W'($signed(xs[i]) >>> i);
    assign ysh = CORDIC_W'($signed(ys[i]) >>> i);

    // Rotate toward the x axis; y at or above zero turns clockwise
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (!ys[i][CORDIC_W-1]) begin
          xs[i+1]  <= xs[i] + ysh;
          ys[i+1]  <= ys[i] - xsh;
          acc[i+1] <= acc[i] + ATAN_I;
        end else begin
          xs[i+1]  <= xs[i] - ysh;
          ys[i+1]  <= ys[i] + xsh;
          acc[i+1] <= acc[i] - ATAN_I;
        end
      end
    end
  end

  assign acc_rnd = acc[STAGES] + (CORDIC_W'(1) << (CORDIC_W - 1 - AW));

  // Round half up to the output angle width; a null vector gives zero
  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= zf[STAGES] ? '0 : acc_rnd[CORDIC_W-1 -: AW];
    end
  end

  assign angle = angle_r;

endmodule

// ----- hdl/cartesian_to_spherical_unit.sv -----
// Path: capture, squares, sums, rho square root, latitude CORDIC and its rounding register.
// Throughput: one point per cycle unless a held result stalls; the longitude CORDIC, both
// square roots and the latitude CORDIC are fully pipelined, and latitude waits on the rho
// square root. A stalled result freezes every stage, so coord_stall follows result_stall.
// Reset (rst, synchronous) clears the valid line only; data registers are not reset.
module cartesian_to_spherical_unit
  import cts_pkg::*;
#(
  parameter int unsigned COORD_WIDTH   = 32,
  parameter int unsigned ANGLE_WIDTH   = 32,
  parameter int unsigned CORDIC_STAGES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          coord_valid,
  output logic                          coord_stall,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic signed [COORD_WIDTH-1:0] coord_z,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [ANGLE_WIDTH-1:0] longitude,
  output logic signed [ANGLE_WIDTH-1:0] latitude,
  output logic        [COORD_WIDTH-1:0] radius
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned GUARD = 62 - CW;
  localparam int unsigned LAT   = CW + CORDIC_STAGES + 5;

  logic               adv;
  logic [LAT-1:0]     vld;

  logic [CW-1:0]       x_r, y_r, z_r;
  logic [2*CW-1:0]     x_sq, y_sq, z_sq;
  logic [2*CW-1:0]     rho_sq, rad_sq;
  logic [CORDIC_W-1:0] xe, ye, lng_x, lng_y, lng_base;
  logic                lng_zero;
  logic [CW-1:0]       ax, ay, az;
  logic [CW-1:0]       rho, rad, z_d, rad_d;
  logic [CORDIC_W-1:0] lat_x, lat_y;
  logic                lat_zero;
  logic [ANGLE_WIDTH-1:0] lng_ang, lng_d, lat_ang;

  // Whole pipe advances unless a finished result is held
  assign adv         = !(vld[LAT-1] && result_stall);
  assign coord_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], coord_valid};
    end
  end

  // Capture the beat
  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= coord_x;
      y_r <= coord_y;
      z_r <= coord_z;
    end
  end

  // Magnitudes, squares and the longitude pre-rotation
  always_comb begin
    ax = x_r[CW-1] ? CW'(-x_r) : x_r;
    ay = y_r[CW-1] ? CW'(-y_r) : y_r;
    az = z_r[CW-1] ? CW'(-z_r) : z_r;
    xe = {{(CORDIC_W-CW){x_r[CW-1]}}, x_r};
    ye = {{(CORDIC_W-CW){y_r[CW-1]}}, y_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_sq     <= ax * ax;
      y_sq     <= ay * ay;
      z_sq     <= az * az;
      lng_x    <= (x_r[CW-1] ? -xe : xe) << GUARD;
      lng_y    <= (x_r[CW-1] ? -ye : ye) << GUARD;
      lng_base <= x_r[CW-1] ? (CORDIC_W'(1) << (CORDIC_W - 1)) : '0;
      lng_zero <= (x_r == '0) && (y_r == '0);
    end
  end

  // Sums of squares; both stay below 2^(2*COORD_WIDTH)
  always_ff @(posedge clk) begin
    if (adv) begin
      rho_sq <= x_sq + y_sq;
      rad_sq <= x_sq + y_sq + z_sq;
    end
  end

  cts_sqrt #(.RW(CW)) u_rho_sqrt (
    .clk  (clk),
    .en   (adv),
    .sq   (rho_sq),
    .root (rho)
  );

  cts_sqrt #(.RW(CW)) u_rad_sqrt (
    .clk  (clk),
    .en   (adv),
    .sq   (rad_sq),
    .root (rad)
  );

  cts_cordic #(.STAGES(CORDIC_STAGES), .AW(ANGLE_WIDTH)) u_lng_cordic (
    .clk   (clk),
    .en    (adv),
    .vec_x (lng_x),
    .vec_y (lng_y),
    .base  (lng_base),
    .zero  (lng_zero),
    .angle (lng_ang)
  );

  // Hold z until rho is ready
  cts_delay #(.WIDTH(CW), .DEPTH(CW + 3)) u_z_delay (
    .clk  (clk),
    .en   (adv),
    .din  (z_r),
    .dout (z_d)
  );

  // Latitude vector from rho and z
  always_comb begin
    lat_x    = CORDIC_W'(rho) << GUARD;
    lat_y    = {{(CORDIC_W-CW){z_d[CW-1]}}, z_d} << GUARD;
    lat_zero = (rho == '0) && (z_d == '0);
  end

  cts_cordic #(.STAGES(CORDIC_STAGES), .AW(ANGLE_WIDTH)) u_lat_cordic (
    .clk   (clk),
    .en    (adv),
    .vec_x (lat_x),
    .vec_y (lat_y),
    .base  ('0),
    .zero  (lat_zero),
    .angle (lat_ang)
  );

  // Align longitude and radius with latitude
  cts_delay #(.WIDTH(ANGLE_WIDTH), .DEPTH(CW + 2)) u_lng_delay (
    .clk  (clk),
    .en   (adv),
    .din  (lng_ang),
    .dout (lng_d)
  );

  cts_delay #(.WIDTH(CW), .DEPTH(CORDIC_STAGES + 1)) u_rad_delay (
    .clk  (clk),
    .en   (adv),
    .din  (rad),
    .dout (rad_d)
  );

  assign result_valid = vld[LAT-1];
  assign longitude    = lng_d;
  assign latitude     = lat_ang;
  assign radius       = rad_d;

endmodule

// ----- hdl/cts_checker.sv -----
// Port-level checks for the spherical converter, bound to the top level.
module cts_checker
  import cts_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned ANGLE_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   coord_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input logic [ANGLE_WIDTH-1:0] longitude,
  input logic [ANGLE_WIDTH-1:0] latitude,
  input logic [COORD_WIDTH-1:0] radius
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // Input is held back exactly when a result is held back
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    coord_stall == (result_valid && result_stall))
    else $error("input stall does not follow output stall");

  // A held result keeps its angles
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(longitude) && $stable(latitude))
    else $error("stalled result changed");

  // Origin gives zero angles
  a_origin: assert property (@(posedge clk) disable iff (rst)
    result_valid && (radius == '0) |-> (longitude == '0) && (latitude == '0))
    else $error("nonzero angle at origin");

endmodule

bind cartesian_to_spherical_unit cts_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .ANGLE_WIDTH(ANGLE_WIDTH)
) u_cts_checker (
  .clk          (clk),
  .rst          (rst),
  .coord_stall  (coord_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .longitude    (longitude),
  .latitude     (latitude),
  .radius       (radius)
);
